// ===== rtl/ctd_pkg.sv =====
// shared types, codes and byte classification for the chunked transfer decoder
package ctd_pkg;

    localparam int SIZE_BITS_DEFAULT   = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] CH_CR          = 8'd13;
    localparam logic [7:0] CH_LF          = 8'd10;
    localparam logic [7:0] LINE_BUF       = 8'd120;
    localparam logic [7:0] MAX_LINE_RESET = LINE_BUF - 8'd1;
    localparam logic [7:0] MIN_LINE       = 8'd3;
    localparam logic [7:0] LINE_SAT       = 8'd255;

    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic ERR_TRAILER = 1'b0;
    localparam logic ERR_LINE    = 1'b1;

    // one classified byte as it sits in the queue
    typedef struct packed {
        logic [7:0] value;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } ctd_item_t;

    function automatic ctd_item_t classify(input logic [7:0] b);
        ctd_item_t it;
        it.value   = b;
        it.is_hex  = 1'b0;
        it.hex_val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            it.is_hex  = 1'b1;
            it.hex_val = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66)
        begin
            it.is_hex  = 1'b1;
            it.hex_val = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46)
        begin
            it.is_hex  = 1'b1;
            it.hex_val = 4'(b - 8'h37);
        end
        it.is_cr = (b == CH_CR);
        it.is_lf = (b == CH_LF);
        return it;
    endfunction

endpackage

// ===== rtl/chunked_transfer_decoder.sv =====
// top level of the chunked transfer decoder: front, queue and back
//
// input channel: one raw byte of a chunked body per request on
//   item_valid / item_stall / in_byte, taken when valid is high and stall low
// output channel: result_valid / result_stall with kind, data, error_code;
//   kind 0 carries a payload byte, kind 1 marks end of body, kind 2 an error
// config: cfg_we / cfg_wdata write max_line_length; the user must do so only
//   while idle, the block itself does not enforce it
// throughput: one byte per cycle while result_stall is low; size-line and
//   trailer bytes produce no result except an end or error, data bytes one each
// a byte passes through the queue, then the back end's output register
// the front stalls only when the queue is full; the queue fills once the
//   receiver holds result_stall high, so a stalled receiver backs up the
//   input after a few requests and nothing is dropped
// after end of body or an error every further byte is consumed silently
// reset: line parsing restarts, the queue empties, max_line_length
//   returns to 119
module chunked_transfer_decoder #(
    parameter int SIZE_BITS   = ctd_pkg::SIZE_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = ctd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] in_byte,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic       error_code
);
    import ctd_pkg::*;

    // classified byte moving front to back
    ctd_item_t push_item;
    ctd_item_t pop_item;
    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_not_empty;

    // front: handshake on the input side plus hex / CR / LF decode
    ctd_front u_front (
        .item_valid (item_valid),
        .item_stall (item_stall),
        .in_byte    (in_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // decoupling queue so each side stalls on its own
    ctd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    // back: framing state machine, size counter, output register
    ctd_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_ready   (queue_not_empty),
        .item         (pop_item),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .data         (data),
        .error_code   (error_code)
    );

endmodule

// ===== rtl/ctd_front.sv =====
// front end: accepts raw bytes and classifies them for the queue
module ctd_front (
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [7:0]           in_byte,
    input  logic                 queue_full,
    output logic                 push,
    output ctd_pkg::ctd_item_t   push_item
);
    import ctd_pkg::*;

    assign item_stall = queue_full;
    assign push       = item_valid & ~queue_full;
    assign push_item  = classify(in_byte);

endmodule

// ===== rtl/ctd_queue.sv =====
// small fifo of classified bytes between front and back
module ctd_queue #(
    parameter int DEPTH = ctd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ctd_pkg::ctd_item_t   push_item,
    input  logic                 pop,
    output ctd_pkg::ctd_item_t   pop_item,
    output logic                 not_empty,
    output logic                 full
);
    import ctd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ctd_item_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == FULL_CNT);
    assign do_push   = push & ~full;
    assign do_pop    = pop & not_empty;
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/ctd_back.sv =====
// back end: chunk framing state machine and output register
module ctd_back #(
    parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    input  logic                 item_ready,
    input  ctd_pkg::ctd_item_t   item,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [1:0]           kind,
    output logic [7:0]           data,
    output logic                 error_code
);
    import ctd_pkg::*;

    localparam logic [2:0] PH_LINE = 3'd0;
    localparam logic [2:0] PH_DATA = 3'd1;
    localparam logic [2:0] PH_CR   = 3'd2;
    localparam logic [2:0] PH_LF   = 3'd3;
    localparam logic [2:0] PH_DONE = 3'd4;
    localparam logic [2:0] PH_FAIL = 3'd5;

    logic [7:0]           max_line_reg;
    logic [2:0]           phase_reg, phase_next;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [7:0]           line_count_reg, line_count_next;
    logic                 last_cr_reg, last_cr_next;
    logic                 digits_open_reg, digits_open_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           kind_reg, kind_next;
    logic [7:0]           data_reg, data_next;
    logic                 err_reg, err_next;
    logic                 emit;
    logic [7:0]           lc_inc;

    assign pop          = item_ready & (~out_valid_reg | ~result_stall);
    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign data         = data_reg;
    assign error_code   = err_reg;
    assign lc_inc       = (line_count_reg < LINE_SAT) ? line_count_reg + 8'd1 : line_count_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        size_next        = size_reg;
        line_count_next  = line_count_reg;
        last_cr_next     = last_cr_reg;
        digits_open_next = digits_open_reg;
        emit             = 1'b0;
        kind_next        = kind_reg;
        data_next        = data_reg;
        err_next         = err_reg;
        if (pop)
        begin
            kind_next = KIND_DATA;
            data_next = 8'd0;
            err_next  = ERR_TRAILER;
            case (phase_reg)
                PH_LINE:
                begin
                    line_count_next = lc_inc;
                    if (item.is_lf)
                    begin
                        if (lc_inc < MIN_LINE || !last_cr_reg)
                        begin
                            phase_next = PH_FAIL;
                            emit       = 1'b1;
                            kind_next  = KIND_ERR;
                            err_next   = ERR_LINE;
                        end
                        else if (size_reg == '0)
                        begin
                            phase_next = PH_DONE;
                            emit       = 1'b1;
                            kind_next  = KIND_END;
                        end
                        else
                        begin
                            phase_next       = PH_DATA;
                            line_count_next  = 8'd0;
                            last_cr_next     = 1'b0;
                            digits_open_next = 1'b1;
                        end
                    end
                    else if (lc_inc >= max_line_reg)
                    begin
                        phase_next = PH_FAIL;
                        emit       = 1'b1;
                        kind_next  = KIND_ERR;
                        err_next   = ERR_LINE;
                    end
                    else
                    begin
                        if (digits_open_reg)
                        begin
                            if (item.is_hex)
                            begin
                                size_next = {size_reg[SIZE_BITS-5:0], item.hex_val};
                            end
                            else
                            begin
                                digits_open_next = 1'b0;
                            end
                        end
                        last_cr_next = item.is_cr;
                    end
                end
                PH_DATA:
                begin
                    size_next = size_reg - SIZE_BITS'(1);
                    if (size_reg == SIZE_BITS'(1))
                    begin
                        phase_next = PH_CR;
                    end
                    emit      = 1'b1;
                    kind_next = KIND_DATA;
                    data_next = item.value;
                end
                PH_CR:
                begin
                    if (!item.is_cr)
                    begin
                        phase_next = PH_FAIL;
                        emit       = 1'b1;
                        kind_next  = KIND_ERR;
                        err_next   = ERR_TRAILER;
                    end
                    else
                    begin
                        phase_next = PH_LF;
                    end
                end
                PH_LF:
                begin
                    if (!item.is_lf)
                    begin
                        phase_next = PH_FAIL;
                        emit       = 1'b1;
                        kind_next  = KIND_ERR;
                        err_next   = ERR_TRAILER;
                    end
                    else
                    begin
                        phase_next       = PH_LINE;
                        size_next        = '0;
                        line_count_next  = 8'd0;
                        last_cr_next     = 1'b0;
                        digits_open_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
        if (pop)
        begin
            out_valid_next = emit;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_line_reg    <= MAX_LINE_RESET;
            phase_reg       <= PH_LINE;
            size_reg        <= '0;
            line_count_reg  <= 8'd0;
            last_cr_reg     <= 1'b0;
            digits_open_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_line_reg <= cfg_wdata;
            end
            phase_reg       <= phase_next;
            size_reg        <= size_next;
            line_count_reg  <= line_count_next;
            last_cr_reg     <= last_cr_next;
            digits_open_reg <= digits_open_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            err_reg  <= err_next;
        end
    end

endmodule
